FILE: sv/arp_pkg.sv
// Shared types and constants for the ARP cache and responder.
package arp_pkg;

    // Item kinds carried in the input tuser field.
    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_PACKET = 2'd2;

    // ARP opcodes as carried on the wire.
    localparam logic [15:0] OP_REQUEST = 16'h0001;
    localparam logic [15:0] OP_REPLY   = 16'h0002;

    // Configuration register indexes.
    localparam logic CFG_OWN_IP  = 1'b0;
    localparam logic CFG_OWN_MAC = 1'b1;

    // Gateway entry present in slot zero after reset.
    localparam logic [31:0] GW_IP  = 32'h0A00_0201;
    localparam logic [47:0] GW_MAC = 48'h5255_0A00_0202;

    // Field widths.
    localparam int IP_W  = 32;
    localparam int MAC_W = 48;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_WRITE,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the accepted item
        logic rd_en;     // read the table entry at the scan index
        logic cmp_en;    // compare the entry read in the previous cycle
        logic wr_en;     // write the learned pair into the chosen slot
        logic out_load;  // move the finished result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic learn;     // the current item writes a table entry
        logic reply;     // the current item asks for an ARP reply
        logic out_free;  // the output register can take a result this cycle
    } t_stat;

endpackage

FILE: sv/arp_ctrl.sv
// Controller state machine that sequences the table scan, write and result hand-off.
module arp_ctrl import arp_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  t_stat                      i_stat,
    output t_cmd                       o_cmd,
    output logic [$clog2(ENTRIES)-1:0] o_idx,
    output logic                       o_ready
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;

    // State and scan index registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Next state and scan index.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (i_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ST_LAST;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_LAST: begin
                n_state = i_stat.learn ? ST_WRITE : ST_DONE;
            end
            ST_WRITE: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands for the datapath.
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_accept;
            end
            ST_SCAN: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.cmp_en = (r_idx != '0);
            end
            ST_LAST: begin
                o_cmd.cmp_en = 1'b1;
            end
            ST_WRITE: begin
                o_cmd.wr_en = 1'b1;
            end
            ST_DONE: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_idx = r_idx;

endmodule

FILE: sv/arp_dpath.sv
// Datapath: address table, item registers, scan compare and output register.
module arp_dpath import arp_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  logic [$clog2(ENTRIES)-1:0] i_idx,
    output t_stat                      o_stat,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_addr,
    input  logic [MAC_W-1:0]           i_cfg_wdata,
    input  logic [1:0]                 i_mode,
    input  logic [15:0]                i_opcode,
    input  logic [IP_W-1:0]            i_peer_ip,
    input  logic [MAC_W-1:0]           i_peer_mac,
    input  logic [IP_W-1:0]            i_asked_ip,
    input  logic                       i_m_tready,
    output logic                       o_m_tvalid,
    output logic                       o_found,
    output logic [MAC_W-1:0]           o_result_mac,
    output logic                       o_send_reply,
    output logic [IP_W-1:0]            o_reply_ip
);

    localparam int IW = $clog2(ENTRIES);

    // Table storage; an entry is meaningful only while its valid bit is set.
    logic [IP_W-1:0]  mem_ip  [ENTRIES];
    logic [MAC_W-1:0] mem_mac [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic               r_gw;     // slot zero still holds the gateway pair

    // Configuration registers.
    logic [IP_W-1:0]  r_own_ip;
    logic [MAC_W-1:0] r_own_mac;

    // Current item.
    logic [IP_W-1:0]  r_peer_ip;
    logic [MAC_W-1:0] r_peer_mac;
    logic             r_lookup, r_learn, r_reply;

    // Read stage.
    logic [IP_W-1:0]  r_rd_ip;
    logic [MAC_W-1:0] r_rd_mac;
    logic [IW-1:0]    r_rd_idx;
    logic             r_rd_vld, r_rd_gw;

    // Scan results.
    logic             r_found;
    logic [MAC_W-1:0] r_mac;
    logic             r_free_ok;
    logic [IW-1:0]    r_free_idx;

    // Output register.
    logic             r_out_vld;
    logic             r_out_found, r_out_send;
    logic [MAC_W-1:0] r_out_mac;
    logic [IP_W-1:0]  r_out_ip;

    logic             own_hit;
    logic             n_learn, n_reply;
    logic [IP_W-1:0]  eff_ip;
    logic [MAC_W-1:0] eff_mac;
    logic             hit;
    logic [IW-1:0]    slot;

    // Item decode at accept time.
    assign own_hit = (i_asked_ip == r_own_ip);
    assign n_reply = (i_mode == MODE_PACKET) && (i_opcode == OP_REQUEST) && own_hit;
    assign n_learn = (i_mode == MODE_ADD) || n_reply
                   || ((i_mode == MODE_PACKET) && (i_opcode == OP_REPLY));

    // Entry seen in the compare stage, with the gateway standing in for slot zero.
    assign eff_ip  = r_rd_gw ? GW_IP  : r_rd_ip;
    assign eff_mac = r_rd_gw ? GW_MAC : r_rd_mac;
    assign hit     = r_rd_vld && (eff_ip == r_peer_ip);

    // First free slot, or slot zero when the table is full.
    assign slot = r_free_ok ? r_free_idx : '0;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip  <= '0;
            r_own_mac <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_OWN_IP:  r_own_ip  <= i_cfg_wdata[IP_W-1:0];
                CFG_OWN_MAC: r_own_mac <= i_cfg_wdata;
                default:     r_own_ip  <= r_own_ip;
            endcase
        end
    end

    // Table memory: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && r_learn) begin
            mem_ip[slot]  <= r_peer_ip;
            mem_mac[slot] <= r_peer_mac;
        end
        if (i_cmd.rd_en) begin
            r_rd_ip  <= mem_ip[i_idx];
            r_rd_mac <= mem_mac[i_idx];
            r_rd_idx <= i_idx;
        end
    end

    // Valid bits and gateway flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= ENTRIES'(1);
            r_gw     <= 1'b1;
            r_rd_vld <= 1'b0;
            r_rd_gw  <= 1'b0;
        end else begin
            if (i_cmd.rd_en) begin
                r_rd_vld <= r_valid[i_idx];
                r_rd_gw  <= r_gw && (i_idx == '0);
            end
            if (i_cmd.wr_en && r_learn) begin
                r_valid[slot] <= 1'b1;
                if (slot == '0) begin
                    r_gw <= 1'b0;
                end
            end
        end
    end

    // Item capture and scan bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookup  <= 1'b0;
            r_learn   <= 1'b0;
            r_reply   <= 1'b0;
            r_found   <= 1'b0;
            r_free_ok <= 1'b0;
        end else if (i_cmd.load) begin
            r_lookup  <= (i_mode == MODE_LOOKUP);
            r_learn   <= n_learn;
            r_reply   <= n_reply;
            r_found   <= 1'b0;
            r_free_ok <= 1'b0;
        end else if (i_cmd.cmp_en) begin
            if (hit && !r_found) begin
                r_found <= 1'b1;
            end
            if (!r_rd_vld && !r_free_ok) begin
                r_free_ok <= 1'b1;
            end
        end
    end

    // Payload of the item and scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_peer_ip  <= i_peer_ip;
            r_peer_mac <= i_peer_mac;
            r_mac      <= '0;
        end else if (i_cmd.cmp_en) begin
            if (hit && !r_found) begin
                r_mac <= eff_mac;
            end
            if (!r_rd_vld && !r_free_ok) begin
                r_free_idx <= r_rd_idx;
            end
        end
    end

    // Output register; it holds a result until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_found <= r_lookup && r_found;
            r_out_send  <= r_reply;
            r_out_mac   <= r_lookup ? r_mac : (r_reply ? r_peer_mac : '0);
            r_out_ip    <= r_reply ? r_peer_ip : '0;
        end
    end

    assign o_stat.learn    = r_learn;
    assign o_stat.reply    = r_reply;
    assign o_stat.out_free = !r_out_vld || i_m_tready;

    assign o_m_tvalid   = r_out_vld;
    assign o_found      = r_out_found;
    assign o_send_reply = r_out_send;
    assign o_result_mac = r_out_mac;
    assign o_reply_ip   = r_out_ip;

endmodule

FILE: sv/arp_cache_and_responder_top.sv
// ARP cache and responder: top level joining the controller and the datapath.
//
// The block keeps a table of ENTRIES IPv4-to-MAC pairs and answers one item at a time: a
// lookup returns the MAC of the lowest valid matching entry, an add stores a pair in the
// first free slot (slot zero when full), a received ARP reply learns the sender, and a
// request aimed at own_ip learns the sender and asks for a reply. Every input item yields
// exactly one result item. The table is scanned through a single read port, one entry per
// cycle, and an item keeps the input closed until its result can enter the output
// register. A finished result sits in the output register, so the next item is taken
// while it waits. After reset slot zero holds the gateway 10.0.2.1 at 52:55:0A:00:02:02;
// no clearing pass is needed. The user must write configuration only while the block is
// idle; the block itself does not enforce this.
module arp_cache_and_responder_top import arp_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write port.
    input  logic         i_cfg_we,
    input  logic         i_cfg_addr,
    input  logic [47:0]  i_cfg_wdata,
    // Input items.
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,   // opcode[15:0], peer_ip[47:16], peer_mac[95:48],
                                      // asked_ip[127:96]
    input  logic [1:0]   i_s_tuser,   // mode[1:0]
    // Result items.
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [79:0]  o_m_tdata,   // result_mac[47:0], reply IP[79:48]
    output logic [1:0]   o_m_tuser    // found[0], send_reply[1]
);

    localparam int IW = $clog2(ENTRIES);

    t_cmd           cmd;
    t_stat          stat;
    logic [IW-1:0]  idx;
    logic           accept;
    logic           found, send_reply;
    logic [47:0]    result_mac;
    logic [31:0]    reply_ip;

    assign accept = i_s_tvalid && o_s_tready;

    arp_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_idx    (idx),
        .o_ready  (o_s_tready)
    );

    arp_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_idx        (idx),
        .o_stat       (stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_mode       (i_s_tuser),
        .i_opcode     (i_s_tdata[15:0]),
        .i_peer_ip    (i_s_tdata[47:16]),
        .i_peer_mac   (i_s_tdata[95:48]),
        .i_asked_ip   (i_s_tdata[127:96]),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_found      (found),
        .o_result_mac (result_mac),
        .o_send_reply (send_reply),
        .o_reply_ip   (reply_ip)
    );

    assign o_m_tdata = {reply_ip, result_mac};
    assign o_m_tuser = {send_reply, found};

    // An accepted item keeps the input closed for the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_tready)
        else $error("input accepted again right after an item");

    // A reply request always learns the sender.
    a_reply_learns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.reply |-> stat.learn)
        else $error("reply requested without learning the sender");

    // Handing off a result makes it visible in the next cycle.
    a_out_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_m_tvalid)
        else $error("result handed off but output not valid");

    // A result never marks both a lookup hit and a reply request.
    a_found_xor_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("result marks both found and send_reply");

endmodule
